### hw/rtl/uyvy_2x2_downscale_to_rgb_defines.svh
// Assertion macros shared by the converter's modules.
`ifndef UYVY_2X2_DOWNSCALE_TO_RGB_DEFINES_SVH
`define UYVY_2X2_DOWNSCALE_TO_RGB_DEFINES_SVH
`ifndef SYNTH
`define UYDS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uyds: assertion failed");
`define UYDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("uyds: assertion failed");
`else
`define UYDS_ASSERT_IMPL(lbl, ante, cons)
`define UYDS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/uyds_pkg.sv
package uyds_pkg;

  localparam int GPR_W     = 13;
  localparam int ROWS_W    = 14;
  localparam int ROW_W     = 13;
  localparam int COL_W     = 13;
  localparam int ROW_LIMIT = 8192;
  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 4;
  localparam int CRED_W    = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [GPR_W-1:0]  GPR_RESET  = 13'd1296;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 14'd1944;

  localparam logic signed [14:0] COEF_RV = 15'sd4669;
  localparam logic signed [14:0] COEF_GU = 15'sd1618;
  localparam logic signed [14:0] COEF_GV = 15'sd2380;
  localparam logic signed [14:0] COEF_BU = 15'sd8323;
  localparam logic signed [9:0]  CHROMA_BIAS = 10'sd256;

  typedef enum logic {
    REG_GROUPS = 1'b0,
    REG_ROWS   = 1'b1
  } reg_sel_t;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_BLEND = 1'b1
  } op_t;

  typedef struct packed {
    logic [7:0] u;
    logic [7:0] y0;
    logic [7:0] v;
    logic [7:0] y1;
  } pix_t;

  typedef struct packed {
    logic [GPR_W-1:0]  groups_per_row;
    logic [ROWS_W-1:0] frame_rows;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [COL_W-1:0] col;
    pix_t             pix;
    logic             frame_end;
  } job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gray;
    logic       frame_end;
  } result_t;

endpackage

### hw/rtl/uyds_fifo.sv
module uyds_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### hw/rtl/uyds_front.sv
module uyds_front #(
  parameter int MAX_GROUPS = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  uyds_pkg::pix_t  pix,
  input  uyds_pkg::cfg_t  cfg,
  output logic            job_push,
  output uyds_pkg::job_t  job,
  input  logic            job_full
);

  localparam int CNT_W = $clog2(MAX_GROUPS);
  localparam int SAT_W = uyds_pkg::ROWS_W;

  logic [CNT_W-1:0]           col_r, col_nxt;
  logic [uyds_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [SAT_W-1:0]           gpr_sat, gpr_m1, rows_sat, rows_m1, pair_rows, pair_m1;
  logic [SAT_W-1:0]           col_x, row_x;
  logic                       accept, last_col, in_pair;

  always_comb begin
    if (cfg.groups_per_row == '0) begin
      gpr_sat = SAT_W'(1);
    end else if (SAT_W'(cfg.groups_per_row) > SAT_W'(MAX_GROUPS)) begin
      gpr_sat = SAT_W'(MAX_GROUPS);
    end else begin
      gpr_sat = SAT_W'(cfg.groups_per_row);
    end
    if (cfg.frame_rows < SAT_W'(2)) begin
      rows_sat = SAT_W'(2);
    end else if (cfg.frame_rows > SAT_W'(uyds_pkg::ROW_LIMIT)) begin
      rows_sat = SAT_W'(uyds_pkg::ROW_LIMIT);
    end else begin
      rows_sat = cfg.frame_rows;
    end
  end

  assign gpr_m1    = gpr_sat - 1'b1;
  assign rows_m1   = rows_sat - 1'b1;
  assign pair_rows = {rows_sat[SAT_W-1:1], 1'b0};
  assign pair_m1   = pair_rows - 1'b1;
  assign col_x     = SAT_W'(col_r);
  assign row_x     = SAT_W'(row_r);
  assign last_col  = (col_x >= gpr_m1);
  assign in_pair   = (row_x < pair_rows);

  assign full     = job_full;
  assign accept   = push && !job_full;
  assign job_push = accept && in_pair;

  always_comb begin
    job.op        = row_r[0] ? uyds_pkg::OP_BLEND : uyds_pkg::OP_STORE;
    job.col       = uyds_pkg::COL_W'(col_r);
    job.pix       = pix;
    job.frame_end = last_col && (row_x >= pair_m1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = (row_x >= rows_m1) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### hw/rtl/uyds_back.sv
`include "uyvy_2x2_downscale_to_rgb_defines.svh"

module uyds_back #(
  parameter int MAX_GROUPS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  uyds_pkg::job_t      job,
  input  logic                job_empty,
  output logic                job_pop,
  input  logic                res_pop,
  output logic                res_push,
  output uyds_pkg::result_t   res
);

  localparam int AW = $clog2(MAX_GROUPS);
  localparam int CW = uyds_pkg::CRED_W;

  typedef struct packed {
    logic [8:0] ysum;
    logic [7:0] u;
    logic [7:0] v;
  } line_t;

  line_t                 mem_r [MAX_GROUPS];
  line_t                 rd_r, wr_line;
  logic [AW-1:0]         addr;
  logic [CW-1:0]         cred_r, cred_nxt;
  logic                  can_blend, blend_go, store_go;

  logic                  a_vld_r;
  uyds_pkg::pix_t        a_pix_r;
  logic                  a_fe_r;

  logic [9:0]            ysum;
  logic signed [9:0]     du, dv;
  logic signed [24:0]    yq, p_rv, p_gu, p_gv, p_bu;

  logic                  b_vld_r;
  logic signed [24:0]    b_yq_r, b_rv_r, b_gu_r, b_gv_r, b_bu_r;
  logic [7:0]            b_gray_r;
  logic                  b_fe_r;
  logic signed [24:0]    r_sum, g_sum, b_sum;

  function automatic logic [7:0] to_byte(input logic signed [24:0] s);
    logic [7:0] q;
    if (s[24]) begin
      q = 8'd0;
    end else if (|s[23:21]) begin
      q = 8'd255;
    end else begin
      q = s[20:13];
    end
    return q;
  endfunction

  assign can_blend = (cred_r < CW'(uyds_pkg::OUT_DEPTH));
  assign job_pop   = !job_empty && ((job.op == uyds_pkg::OP_STORE) || can_blend);
  assign blend_go  = job_pop && (job.op == uyds_pkg::OP_BLEND);
  assign store_go  = job_pop && (job.op == uyds_pkg::OP_STORE);
  assign addr      = job.col[AW-1:0];

  always_comb begin
    wr_line.ysum = 9'(job.pix.y0) + 9'(job.pix.y1);
    wr_line.u    = job.pix.u;
    wr_line.v    = job.pix.v;
  end

  always_ff @(posedge clk) begin
    if (store_go) begin
      mem_r[addr] <= wr_line;
    end
    if (blend_go) begin
      rd_r <= mem_r[addr];
    end
  end

  always_comb begin
    cred_nxt = cred_r;
    if (blend_go && !res_pop) begin
      cred_nxt = cred_r + 1'b1;
    end else if (res_pop && !blend_go) begin
      cred_nxt = cred_r - 1'b1;
    end
  end

  assign ysum = 10'(rd_r.ysum) + 10'(a_pix_r.y0) + 10'(a_pix_r.y1);
  assign du   = $signed({1'b0, 9'(rd_r.u) + 9'(a_pix_r.u)}) - uyds_pkg::CHROMA_BIAS;
  assign dv   = $signed({1'b0, 9'(rd_r.v) + 9'(a_pix_r.v)}) - uyds_pkg::CHROMA_BIAS;
  assign yq   = $signed({4'b0, ysum, 11'b0});
  assign p_rv = 25'(dv) * 25'(uyds_pkg::COEF_RV);
  assign p_gu = 25'(du) * 25'(uyds_pkg::COEF_GU);
  assign p_gv = 25'(dv) * 25'(uyds_pkg::COEF_GV);
  assign p_bu = 25'(du) * 25'(uyds_pkg::COEF_BU);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r  <= '0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      cred_r  <= cred_nxt;
      a_vld_r <= blend_go;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_pix_r  <= job.pix;
    a_fe_r   <= job.frame_end;
    b_yq_r   <= yq;
    b_rv_r   <= p_rv;
    b_gu_r   <= p_gu;
    b_gv_r   <= p_gv;
    b_bu_r   <= p_bu;
    b_gray_r <= ysum[9:2];
    b_fe_r   <= a_fe_r;
  end

  assign r_sum = b_yq_r + b_rv_r;
  assign g_sum = b_yq_r - b_gu_r - b_gv_r;
  assign b_sum = b_yq_r + b_bu_r;

  assign res_push = b_vld_r;

  always_comb begin
    res.red       = to_byte(r_sum);
    res.green     = to_byte(g_sum);
    res.blue      = to_byte(b_sum);
    res.gray      = b_gray_r;
    res.frame_end = b_fe_r;
  end

  `UYDS_ASSERT_IMPL(cred_bound_a, 1'b1, cred_r <= CW'(uyds_pkg::OUT_DEPTH))
  `UYDS_ASSERT_NEXT(blend_latency_a, blend_go, ##1 res_push)
  `UYDS_ASSERT_IMPL(res_credit_a, res_push, cred_r != '0)

endmodule

### hw/rtl/uyvy_2x2_downscale_to_rgb.sv
// UYVY to RGB converter with 2x2 decimation.
// Input requests carry one UYVY group (U, Y0, V, Y1) in raster order and are
// taken at a clock edge with push high and full low. Even rows of each row
// pair are kept in a line store; each group of the odd row yields one result
// request with red, green, blue, gray and frame_end, shown while empty is low
// and taken with pop. A last odd row is consumed and makes no result.
// One group is accepted per cycle while full is low; each result passes the
// input queue, the line store read, the constant multiply stage and the
// output queue. Four-entry queues sit in front of and behind the
// conversion pipeline, so a stalled receiver fills the output queue, then
// the input queue, and only then raises full.
// groups_per_row (address 0) and frame_rows (address 4) must be written over
// APB only while the block is idle; the block does not enforce it. Reset
// clears the counters, both queues and the registers to 1296 and 1944; the
// line store is not cleared, and each even row rewrites what its odd row reads.
`include "uyvy_2x2_downscale_to_rgb_defines.svh"

module uyvy_2x2_downscale_to_rgb #(
  parameter int MAX_GROUPS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_first_u,
  input  logic [7:0]                    in_first_luma,
  input  logic [7:0]                    in_first_v,
  input  logic [7:0]                    in_second_luma,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [7:0]                    out_gray,
  output logic                          out_frame_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uyds_pkg::PADDR_W-1:0]  paddr,
  input  logic [uyds_pkg::PDATA_W-1:0]  pwdata,
  output logic [uyds_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [uyds_pkg::GPR_W-1:0]  gpr_r;
  logic [uyds_pkg::ROWS_W-1:0] rows_r;
  logic                        cfg_wr;
  uyds_pkg::reg_sel_t          reg_sel;
  uyds_pkg::cfg_t              cfg;
  uyds_pkg::pix_t              pix;

  logic                        job_push, job_full, job_empty, job_pop;
  uyds_pkg::job_t              job_in, job_out;
  logic                        res_push, res_full, res_pop;
  uyds_pkg::result_t           res_in, res_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = uyds_pkg::reg_sel_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpr_r  <= uyds_pkg::GPR_RESET;
      rows_r <= uyds_pkg::ROWS_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        uyds_pkg::REG_GROUPS: gpr_r  <= pwdata[uyds_pkg::GPR_W-1:0];
        uyds_pkg::REG_ROWS:   rows_r <= pwdata[uyds_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      uyds_pkg::REG_GROUPS: prdata = uyds_pkg::PDATA_W'(gpr_r);
      uyds_pkg::REG_ROWS:   prdata = uyds_pkg::PDATA_W'(rows_r);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    cfg.groups_per_row = gpr_r;
    cfg.frame_rows     = rows_r;
    pix.u              = in_first_u;
    pix.y0             = in_first_luma;
    pix.v              = in_first_v;
    pix.y1             = in_second_luma;
  end

  uyds_front #(
    .MAX_GROUPS(MAX_GROUPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .pix      (pix),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  uyds_fifo #(
    .WIDTH($bits(uyds_pkg::job_t)),
    .DEPTH(uyds_pkg::IN_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  uyds_back #(
    .MAX_GROUPS(MAX_GROUPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res_pop   (res_pop),
    .res_push  (res_push),
    .res       (res_in)
  );

  uyds_fifo #(
    .WIDTH($bits(uyds_pkg::result_t)),
    .DEPTH(uyds_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign res_pop       = pop && !empty;
  assign out_red       = res_out.red;
  assign out_green     = res_out.green;
  assign out_blue      = res_out.blue;
  assign out_gray      = res_out.gray;
  assign out_frame_end = res_out.frame_end;

  `UYDS_ASSERT_IMPL(res_q_overflow_a, res_push, !res_full)
  `UYDS_ASSERT_IMPL(job_q_overflow_a, job_push, !job_full)

endmodule

### tb/sv/uyvy_2x2_downscale_to_rgb_test.sv
module uyvy_2x2_downscale_to_rgb_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_GROUPS = 4096;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int GROUPS_PER_MODE = 450;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          in_first_u = 8'd0;
  logic [7:0]          in_first_luma = 8'd0;
  logic [7:0]          in_first_v = 8'd0;
  logic [7:0]          in_second_luma = 8'd0;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          out_red;
  logic [7:0]          out_green;
  logic [7:0]          out_blue;
  logic [7:0]          out_gray;
  logic                out_frame_end;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [uyds_pkg::PADDR_W-1:0] paddr = '0;
  logic [uyds_pkg::PDATA_W-1:0] pwdata = '0;
  logic [uyds_pkg::PDATA_W-1:0] prdata;
  logic                pready;

  uyds_pkg::pix_t    pending_groups[$];
  uyds_pkg::result_t expected_blocks[$];
  logic [24:0] line_sums [LINE_GROUPS];
  int          col_pos = 0;
  int          row_pos = 0;
  logic [uyds_pkg::GPR_W-1:0]  gpr_reg = uyds_pkg::GPR_RESET;
  logic [uyds_pkg::ROWS_W-1:0] rows_reg = uyds_pkg::ROWS_RESET;
  int          send_idle_pct = 6;
  int          recv_idle_pct = 63;
  int          mismatches = 0;
  int          groups_queued = 0;
  int          quiet_cycles = 0;

  uyvy_2x2_downscale_to_rgb i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_first_u     (in_first_u),
    .in_first_luma  (in_first_luma),
    .in_first_v     (in_first_v),
    .in_second_luma (in_second_luma),
    .empty          (empty),
    .pop            (pop),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_gray       (out_gray),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int groups_in_use(input logic [uyds_pkg::GPR_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > LINE_GROUPS) return LINE_GROUPS;
    return int'(raw);
  endfunction

  function automatic int rows_in_use(input logic [uyds_pkg::ROWS_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > uyds_pkg::ROW_LIMIT) return uyds_pkg::ROW_LIMIT;
    return int'(raw);
  endfunction

  function automatic logic [7:0] q13_to_byte(input int q13);
    int whole;
    whole = q13 >>> 13;
    if (whole < 0) return 8'd0;
    if (whole > 255) return 8'd255;
    return whole[7:0];
  endfunction

  // Even rows of a pair fill the line store; odd rows combine with it into one block.
  task automatic convert_group(input logic [7:0] u, input logic [7:0] y0,
                               input logic [7:0] v, input logic [7:0] y1);
    int      gpr;
    int      rows;
    int      pair_rows;
    bit      row_end;
    logic [24:0] entry;
    int      ysum;
    int      du;
    int      dv;
    int      yq;
    uyds_pkg::result_t blk;
    gpr = groups_in_use(gpr_reg);
    rows = rows_in_use(rows_reg);
    pair_rows = rows & ~1;
    row_end = (col_pos >= gpr - 1);
    if (row_pos < pair_rows && col_pos < LINE_GROUPS) begin
      if (row_pos % 2 == 0) begin
        line_sums[col_pos] = {({1'b0, y0} + {1'b0, y1}), u, v};
      end else begin
        entry = line_sums[col_pos];
        ysum = int'(entry[24:16]) + int'(y0) + int'(y1);
        du = int'(entry[15:8]) + int'(u) - 256;
        dv = int'(entry[7:0]) + int'(v) - 256;
        yq = 2048 * ysum;
        blk.red = q13_to_byte(yq + 4669 * dv);
        blk.green = q13_to_byte(yq - 1618 * du - 2380 * dv);
        blk.blue = q13_to_byte(yq + 8323 * du);
        blk.gray = ysum[9:2];
        blk.frame_end = row_end && (row_pos >= pair_rows - 1);
        expected_blocks = {expected_blocks, blk};
      end
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = (row_pos >= rows - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic apb_read(input uyds_pkg::reg_sel_t sel,
                          output logic [uyds_pkg::PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input uyds_pkg::reg_sel_t sel,
                                input logic [uyds_pkg::PDATA_W-1:0] want);
    logic [uyds_pkg::PDATA_W-1:0] got;
    apb_read(sel, got);
    if (got !== want) begin
      $display("%0t ns: register %s expected %0d, got %0d", $time, sel.name(), want, got);
      mismatches++;
    end
  endtask

  task automatic apb_write(input uyds_pkg::reg_sel_t sel,
                           input logic [uyds_pkg::PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == uyds_pkg::REG_GROUPS) begin
      gpr_reg = data[uyds_pkg::GPR_W-1:0];
      check_register(sel, uyds_pkg::PDATA_W'(gpr_reg));
    end else begin
      rows_reg = data[uyds_pkg::ROWS_W-1:0];
      check_register(sel, uyds_pkg::PDATA_W'(rows_reg));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_groups.size() != 0 || push || expected_blocks.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_group(input uyds_pkg::pix_t group);
    pending_groups = {pending_groups, group};
    groups_queued++;
  endtask

  always @(posedge clk) begin : send_requests
    uyds_pkg::pix_t next_group;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        convert_group(in_first_u, in_first_luma, in_first_v, in_second_luma);
      end
      if (!push || !full) begin
        if (pending_groups.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_group = pending_groups.pop_front();
          push <= 1'b1;
          in_first_u <= next_group.u;
          in_first_luma <= next_group.y0;
          in_first_v <= next_group.v;
          in_second_luma <= next_group.y1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : take_results
    uyds_pkg::result_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t ns: result request with none expected, rgb %0d %0d %0d gray %0d",
                   $time, out_red, out_green, out_blue, out_gray);
          mismatches++;
        end else begin
          want = expected_blocks.pop_front();
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
          check_field("gray", want.gray, out_gray);
          check_field("frame_end", {7'd0, want.frame_end}, {7'd0, out_frame_end});
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("uyvy_2x2_downscale_to_rgb_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int gpr;
    int rows;
    int new_gpr;
    int new_rows;
    int which;
    int remaining;
    int count;
    int target;
    logic [uyds_pkg::PDATA_W-1:0] wdata;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    check_register(uyds_pkg::REG_GROUPS, uyds_pkg::PDATA_W'(uyds_pkg::GPR_RESET));
    check_register(uyds_pkg::REG_ROWS, uyds_pkg::PDATA_W'(uyds_pkg::ROWS_RESET));

    // Each directed request is packed as U, Y0, V, Y1 from the top byte down.
    apb_write(uyds_pkg::REG_GROUPS, 32'd2);
    apb_write(uyds_pkg::REG_ROWS, 32'd3);
    queue_group(32'h0000_0000);
    queue_group(32'hFFFF_FFFF);
    queue_group(32'h0000_0000);
    queue_group(32'hFFFF_FFFF);
    queue_group(32'h1234_5678);
    queue_group(32'h9ABC_DEF0);
    queue_group(32'hFF00_0000);
    queue_group(32'h00FF_FF00);
    queue_group(32'hFF00_0000);
    queue_group(32'h0000_FFFF);
    queue_group(32'h8080_8080);
    queue_group(32'hFF00_FF00);
    wait_idle();
    apb_write(uyds_pkg::REG_GROUPS, 32'd0);
    apb_write(uyds_pkg::REG_ROWS, 32'd1);
    queue_group(32'h00FF_FF00);
    queue_group(32'hFF00_00FF);
    wait_idle();
    apb_write(uyds_pkg::REG_GROUPS, 32'hFFFF_FFFF);
    apb_write(uyds_pkg::REG_ROWS, 32'hFFFF_FFFF);
    queue_group(32'h40C0_20E0);
    queue_group(32'hC040_E020);
    queue_group(32'h7F80_817E);
    wait_idle();
    apb_write(uyds_pkg::REG_GROUPS, 32'd2);
    queue_group(32'h0102_0304);
    queue_group(32'hA0B0_C0D0);
    queue_group(32'h0F1E_2D3C);
    wait_idle();
    apb_write(uyds_pkg::REG_ROWS, 32'd2);
    queue_group(32'h5555_AAAA);
    queue_group(32'hAAAA_5555);

    for (int mode = 0; mode < 3; mode++) begin
      wait_idle();
      case (mode)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = groups_queued + GROUPS_PER_MODE;
      while (groups_queued < target) begin
        wait_idle();
        gpr = groups_in_use(gpr_reg);
        rows = rows_in_use(rows_reg);
        if (row_pos == 0 && col_pos == 0) begin
          case ($urandom_range(19))
            0: new_gpr = 0;
            1: new_gpr = $urandom_range(8191, LINE_GROUPS);
            2, 3: new_gpr = $urandom_range(40, 9);
            default: new_gpr = $urandom_range(8, 1);
          endcase
          case ($urandom_range(19))
            0: new_rows = $urandom_range(1, 0);
            1: new_rows = $urandom_range(16383, uyds_pkg::ROW_LIMIT);
            2, 3: new_rows = $urandom_range(12, 8);
            default: new_rows = $urandom_range(7, 2);
          endcase
        end else begin
          // Mid frame, only shrink so that an odd row never reads a group its even row skipped.
          new_gpr = ($urandom_range(3) == 0) ? $urandom_range(gpr, 1)
                                             : $urandom_range((gpr < 8) ? gpr : 8, 1);
          new_rows = ($urandom_range(3) == 0) ? $urandom_range(rows, 2)
                                              : $urandom_range((rows < 7) ? rows : 7, 2);
        end
        which = $urandom_range(2);
        if (which != 1) begin
          wdata = $urandom();
          wdata[uyds_pkg::GPR_W-1:0] = new_gpr[uyds_pkg::GPR_W-1:0];
          apb_write(uyds_pkg::REG_GROUPS, wdata);
        end
        if (which != 0) begin
          wdata = $urandom();
          wdata[uyds_pkg::ROWS_W-1:0] = new_rows[uyds_pkg::ROWS_W-1:0];
          apb_write(uyds_pkg::REG_ROWS, wdata);
        end
        gpr = groups_in_use(gpr_reg);
        rows = rows_in_use(rows_reg);
        remaining = ((col_pos >= gpr - 1) ? 1 : gpr - col_pos)
                  + ((row_pos >= rows - 1) ? 0 : (rows - 1 - row_pos) * gpr);
        if (remaining > 300) begin
          count = $urandom_range(60, 1);
        end else if ($urandom_range(3) == 0) begin
          count = $urandom_range(remaining, 1);
        end else if (gpr * rows <= 300) begin
          count = remaining + $urandom_range(2) * gpr * rows;
        end else begin
          count = remaining;
        end
        repeat (count) queue_group($urandom());
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("uyvy_2x2_downscale_to_rgb_test: PASS");
    end else begin
      $display("uyvy_2x2_downscale_to_rgb_test: FAIL");
    end
    $finish;
  end

endmodule
